### sv/cnalu_pkg.sv
// shared types, codes and helpers of the complex number alu
`default_nettype none
package cnalu_pkg;

    localparam int FRAC_BITS_DEF = 16;

    typedef logic [2:0] action_t;
    localparam action_t ACT_ADD  = 3'd0;
    localparam action_t ACT_SUB  = 3'd1;
    localparam action_t ACT_MUL  = 3'd2;
    localparam action_t ACT_DIV  = 3'd3;
    localparam action_t ACT_POW  = 3'd4;
    localparam action_t ACT_CONJ = 3'd5;
    localparam action_t ACT_NEG  = 3'd6;
    localparam action_t ACT_PLUS = 3'd7;

    localparam int QUOT_CAP_BIT = 40;

    typedef struct packed {
        logic load;
        logic simple;
        logic mul_step;
        logic sum;
        logic red;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_simple;
        logic is_div;
        logic mul_last;
        logic rounds_last;
        logic div_last;
    } stat_t;

    // returns {clipped, value} for a sign and magnitude
    function automatic logic [32:0] sat_smag(input logic neg, input logic [64:0] mag);
        logic [32:0] r;
        if (!neg)
        begin
            if (mag > 65'h0_7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, mag[31:0]};
        end
        else
        begin
            if (mag > 65'h0_8000_0000)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, 32'd0 - mag[31:0]};
        end
        return r;
    endfunction

    // returns {clipped, value} for a 33-bit sum
    function automatic logic [32:0] sat33(input logic [32:0] v);
        logic [32:0] r;
        if (v[32] != v[31])
            r = {1'b1, (v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/cnalu_dpath.sv
// datapath: operand registers, shared multiplier, sums, two-lane divider, output word
`default_nettype none
module cnalu_dpath
    import cnalu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cmd_t          cmd,
    output stat_t              stat,
    input  wire action_t       in_action,
    input  wire logic [31:0]   in_a_re,
    input  wire logic [31:0]   in_a_im,
    input  wire logic [31:0]   in_b_re,
    input  wire logic [31:0]   in_b_im,
    input  wire logic [7:0]    in_exponent,
    output logic [31:0]        out_re,
    output logic [31:0]        out_im,
    output logic               out_dz,
    output logic               out_sat
);

    localparam int NUM_W = 64 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int QW    = QUOT_CAP_BIT + 1;

    action_t op_reg;
    logic [31:0] a_re_reg, a_im_reg, y_re_reg, y_im_reg, b_re_reg, b_im_reg;
    logic [7:0]  exp_reg;
    logic [7:0]  rounds_reg;
    logic [2:0]  idx_reg;
    logic [CNT_W-1:0] dcnt_reg;
    logic signed [63:0] p_reg [6];
    logic signed [64:0] sum_re_reg, sum_im_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_re_reg, rem_im_reg;
    logic [NUM_W-1:0] num_re_reg, num_im_reg;
    logic [QW-1:0] q_re_reg, q_im_reg;
    logic big_re_reg, big_im_reg;
    logic [31:0] res_re_reg, res_im_reg;
    logic dz_reg, sat_reg;
    logic [31:0] out_re_reg, out_im_reg;
    logic out_dz_reg, out_sat_reg;

    logic signed [31:0] mx, my;
    logic signed [63:0] mprod;
    logic [64:0] mag_re, mag_im;
    logic [32:0] red_re, red_im;
    logic [32:0] simp_re, simp_im;
    logic simp_dz;
    logic [32:0] fin_re, fin_im;
    logic [63:0] rs_re, rs_im;
    logic ge_re, ge_im;
    logic [QW-1:0] qn_re, qn_im;
    logic b_zero;

    assign b_zero = (b_re_reg == 32'd0) && (b_im_reg == 32'd0);

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    begin mx = a_re_reg; my = y_re_reg; end
            3'd1:    begin mx = a_im_reg; my = y_im_reg; end
            3'd2:    begin mx = a_re_reg; my = y_im_reg; end
            3'd3:    begin mx = a_im_reg; my = y_re_reg; end
            3'd4:    begin mx = y_re_reg; my = y_re_reg; end
            default: begin mx = y_im_reg; my = y_im_reg; end
        endcase
        mprod = mx * my;
    end

    always_comb
    begin
        mag_re = sum_re_reg[64] ? 65'(-sum_re_reg) : 65'(sum_re_reg);
        mag_im = sum_im_reg[64] ? 65'(-sum_im_reg) : 65'(sum_im_reg);
        red_re = sat_smag(sum_re_reg[64], mag_re >> FRAC_BITS);
        red_im = sat_smag(sum_im_reg[64], mag_im >> FRAC_BITS);
    end

    always_comb
    begin
        rs_re = {rem_re_reg[62:0], num_re_reg[NUM_W-1]};
        rs_im = {rem_im_reg[62:0], num_im_reg[NUM_W-1]};
        ge_re = rs_re >= den_reg;
        ge_im = rs_im >= den_reg;
        qn_re = {q_re_reg[QW-2:0], ge_re};
        qn_im = {q_im_reg[QW-2:0], ge_im};
        fin_re = sat_smag(sum_re_reg[64],
                 big_re_reg ? (65'd1 << QUOT_CAP_BIT) : 65'(q_re_reg));
        fin_im = sat_smag(sum_im_reg[64],
                 big_im_reg ? (65'd1 << QUOT_CAP_BIT) : 65'(q_im_reg));
    end

    always_comb
    begin
        simp_re = 33'd0;
        simp_im = 33'd0;
        simp_dz = 1'b0;
        unique case (op_reg)
            ACT_ADD:
            begin
                simp_re = sat33({a_re_reg[31], a_re_reg} + {b_re_reg[31], b_re_reg});
                simp_im = sat33({a_im_reg[31], a_im_reg} + {b_im_reg[31], b_im_reg});
            end
            ACT_SUB:
            begin
                simp_re = sat33({a_re_reg[31], a_re_reg} - {b_re_reg[31], b_re_reg});
                simp_im = sat33({a_im_reg[31], a_im_reg} - {b_im_reg[31], b_im_reg});
            end
            ACT_MUL:
            begin
                simp_re = 33'd0;
            end
            ACT_DIV:
            begin
                simp_dz = 1'b1;
            end
            ACT_POW:
            begin
                if (exp_reg == 8'd0)
                    simp_re = {1'b0, 32'd1 << FRAC_BITS};
                else
                begin
                    simp_re = {1'b0, a_re_reg};
                    simp_im = {1'b0, a_im_reg};
                end
            end
            ACT_CONJ:
            begin
                simp_re = {1'b0, a_re_reg};
                simp_im = sat33(33'd0 - {a_im_reg[31], a_im_reg});
            end
            ACT_NEG:
            begin
                simp_re = sat33(33'd0 - {a_re_reg[31], a_re_reg});
                simp_im = sat33(33'd0 - {a_im_reg[31], a_im_reg});
            end
            ACT_PLUS:
            begin
                simp_re = {1'b0, a_re_reg};
                simp_im = {1'b0, a_im_reg};
            end
        endcase
    end

    always_comb
    begin
        stat.is_div      = (op_reg == ACT_DIV);
        stat.is_simple   = !((op_reg == ACT_MUL) || (op_reg == ACT_DIV && !b_zero)
                           || (op_reg == ACT_POW && exp_reg > 8'd1));
        stat.mul_last    = (op_reg == ACT_DIV) ? (idx_reg == 3'd5) : (idx_reg == 3'd3);
        stat.rounds_last = (rounds_reg == 8'd1);
        stat.div_last    = (dcnt_reg == CNT_W'(NUM_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= 3'd0;
            rounds_reg <= 8'd0;
            dcnt_reg   <= '0;
        end
        else
        begin
            if (cmd.load || cmd.red)
                idx_reg <= 3'd0;
            else if (cmd.mul_step)
                idx_reg <= idx_reg + 3'd1;
            if (cmd.load)
                rounds_reg <= (in_action == ACT_POW) ? in_exponent - 8'd1 : 8'd1;
            else if (cmd.red)
                rounds_reg <= rounds_reg - 8'd1;
            if (cmd.div_init)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_action;
            a_re_reg <= in_a_re;
            a_im_reg <= in_a_im;
            b_re_reg <= in_b_re;
            b_im_reg <= in_b_im;
            y_re_reg <= (in_action == ACT_POW) ? in_a_re : in_b_re;
            y_im_reg <= (in_action == ACT_POW) ? in_a_im : in_b_im;
            exp_reg  <= in_exponent;
            sat_reg  <= 1'b0;
            dz_reg   <= 1'b0;
        end
        if (cmd.mul_step)
            p_reg[idx_reg] <= mprod;
        if (cmd.sum)
        begin
            if (op_reg == ACT_DIV)
            begin
                sum_re_reg <= 65'(p_reg[0]) + 65'(p_reg[1]);
                sum_im_reg <= 65'(p_reg[3]) - 65'(p_reg[2]);
            end
            else
            begin
                sum_re_reg <= 65'(p_reg[0]) - 65'(p_reg[1]);
                sum_im_reg <= 65'(p_reg[2]) + 65'(p_reg[3]);
            end
            den_reg <= 64'(p_reg[4]) + 64'(p_reg[5]);
        end
        if (cmd.simple)
        begin
            res_re_reg <= simp_re[31:0];
            res_im_reg <= simp_im[31:0];
            dz_reg     <= simp_dz;
            sat_reg    <= simp_re[32] | simp_im[32];
        end
        if (cmd.red)
        begin
            res_re_reg <= red_re[31:0];
            res_im_reg <= red_im[31:0];
            y_re_reg   <= red_re[31:0];
            y_im_reg   <= red_im[31:0];
            sat_reg    <= sat_reg | red_re[32] | red_im[32];
        end
        if (cmd.div_init)
        begin
            rem_re_reg <= 64'd0;
            rem_im_reg <= 64'd0;
            num_re_reg <= NUM_W'(mag_re[63:0]) << FRAC_BITS;
            num_im_reg <= NUM_W'(mag_im[63:0]) << FRAC_BITS;
            q_re_reg   <= '0;
            q_im_reg   <= '0;
            big_re_reg <= 1'b0;
            big_im_reg <= 1'b0;
        end
        if (cmd.div_step)
        begin
            rem_re_reg <= ge_re ? rs_re - den_reg : rs_re;
            rem_im_reg <= ge_im ? rs_im - den_reg : rs_im;
            num_re_reg <= num_re_reg << 1;
            num_im_reg <= num_im_reg << 1;
            if (!big_re_reg)
            begin
                q_re_reg   <= qn_re;
                big_re_reg <= qn_re[QW-1];
            end
            if (!big_im_reg)
            begin
                q_im_reg   <= qn_im;
                big_im_reg <= qn_im[QW-1];
            end
        end
        if (cmd.div_fin)
        begin
            res_re_reg <= fin_re[31:0];
            res_im_reg <= fin_im[31:0];
            sat_reg    <= fin_re[32] | fin_im[32];
        end
        if (cmd.out_load)
        begin
            out_re_reg  <= res_re_reg;
            out_im_reg  <= res_im_reg;
            out_dz_reg  <= dz_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign out_re  = out_re_reg;
    assign out_im  = out_im_reg;
    assign out_dz  = out_dz_reg;
    assign out_sat = out_sat_reg;

endmodule
`default_nettype wire

### sv/cnalu_ctrl.sv
// controller: sequences one operation and owns the output valid
`default_nettype none
module cnalu_ctrl
    import cnalu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_MUL      = 9'b000000100,
        S_SUM      = 9'b000001000,
        S_RED      = 9'b000010000,
        S_DIV_INIT = 9'b000100000,
        S_DIV_STEP = 9'b001000000,
        S_DIV_FIN  = 9'b010000000,
        S_OUT      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_simple)
                begin
                    cmd.simple = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum = 1'b1;
                state_next = stat.is_div ? S_DIV_INIT : S_RED;
            end
            S_RED:
            begin
                cmd.red = 1'b1;
                state_next = stat.rounds_last ? S_OUT : S_MUL;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_DIV_FIN;
            end
            S_DIV_FIN:
            begin
                cmd.div_fin = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### sv/complex_number_alu_unit.sv
// top level of the fixed-point complex number alu
//
//  channel  | dir | payload
//  s_*      | in  | tdata a_re, a_im, b_re, b_im, exponent; tuser action
//  m_*      | out | tdata res_re, res_im; tuser div_zero, saturated
//
// add, sub, conjugate, negate, plus, power 0/1, divide by zero: simple path
// multiply, power n: products on one shared 32x32 multiplier, sum, reduction
// divide: products, sums, then the bit-serial two-lane divider
// a new word is taken only when the controller is idle; a finished result
// waits in the output register without blocking the next word
// rst_n clears the controller and the output valid asynchronously
`default_nettype none
module complex_number_alu_unit
    import cnalu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [135:0]  s_tdata,   // a_re, a_im, b_re, b_im, exponent
    input  wire logic [2:0]    s_tuser,   // action
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,   // res_re, res_im
    output logic [1:0]         m_tuser    // div_zero, saturated
);

    cmd_t  cmd;
    stat_t stat;
    logic [31:0] res_re, res_im;
    logic dz, sat;

    cnalu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cnalu_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_action   (s_tuser),
        .in_a_re     (s_tdata[31:0]),
        .in_a_im     (s_tdata[63:32]),
        .in_b_re     (s_tdata[95:64]),
        .in_b_im     (s_tdata[127:96]),
        .in_exponent (s_tdata[135:128]),
        .out_re      (res_re),
        .out_im      (res_im),
        .out_dz      (dz),
        .out_sat     (sat)
    );

    assign m_tdata = {res_im, res_re};
    assign m_tuser = {sat, dz};

endmodule
`default_nettype wire

### sv/cnalu_checker.sv
// port-level checker for the complex number alu and its bind
`default_nettype none
module cnalu_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          s_tvalid,
    input wire logic          s_tready,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [63:0]   m_tdata,
    input wire logic [1:0]    m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0 && !m_tuser[1])
        else $error("divide by zero word not zero or flagged saturated");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in progress");

endmodule

bind complex_number_alu_unit cnalu_checker u_cnalu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench of the complex number alu with a bit-exact fixed-point predictor
`default_nettype none
module tb_top
    import cnalu_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        sat;
    } cres_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [135:0]  s_tdata = '0;
    logic [2:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   m_tdata;
    logic [1:0]    m_tuser;

    cres_t expected_q[$];
    int    errors = 0;
    bit    idle_on = 1'b1;

    complex_number_alu_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    // saturate a signed value to 32 bits, raising the clip flag
    function automatic logic [31:0] clip(input logic signed [127:0] v, inout logic flag);
        if (v > 128'sh7FFF_FFFF)
        begin
            flag = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sh8000_0000)
        begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // truncate toward zero by a shift
    function automatic logic signed [127:0] trunc_shr(input logic signed [127:0] v);
        logic signed [127:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    // scaled quotient toward zero, magnitude capped at 2^40
    function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic signed [127:0] m;
        m = (((n < 0) ? -n : n) << FB) / d;
        if (m > (128'sd1 <<< 40))
            m = 128'sd1 <<< 40;
        return (n < 0) ? -m : m;
    endfunction

    function automatic void cplx_mul(input logic signed [31:0] xr, input logic signed [31:0] xi,
                                     input logic signed [31:0] yr, input logic signed [31:0] yi,
                                     output logic [31:0] zr, output logic [31:0] zi,
                                     inout logic flag);
        logic signed [127:0] r, i;
        r = 128'(xr) * 128'(yr) - 128'(xi) * 128'(yi);
        i = 128'(xr) * 128'(yi) + 128'(xi) * 128'(yr);
        zr = clip(trunc_shr(r), flag);
        zi = clip(trunc_shr(i), flag);
    endfunction

    function automatic cres_t alu_predict(input action_t op, input logic signed [31:0] ar,
                                          input logic signed [31:0] ai,
                                          input logic signed [31:0] br,
                                          input logic signed [31:0] bi,
                                          input logic [7:0] n);
        cres_t r;
        logic signed [127:0] den, nr, ni;
        logic [31:0] tr, ti;
        r = '0;
        case (op)
            ACT_ADD:
            begin
                r.re = clip(128'(ar) + 128'(br), r.sat);
                r.im = clip(128'(ai) + 128'(bi), r.sat);
            end
            ACT_SUB:
            begin
                r.re = clip(128'(ar) - 128'(br), r.sat);
                r.im = clip(128'(ai) - 128'(bi), r.sat);
            end
            ACT_MUL: cplx_mul(ar, ai, br, bi, r.re, r.im, r.sat);
            ACT_DIV:
            begin
                if (br == 0 && bi == 0)
                    r.dz = 1'b1;
                else
                begin
                    den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
                    nr = 128'(ar) * 128'(br) + 128'(ai) * 128'(bi);
                    ni = 128'(ai) * 128'(br) - 128'(ar) * 128'(bi);
                    r.re = clip(trunc_div(nr, den), r.sat);
                    r.im = clip(trunc_div(ni, den), r.sat);
                end
            end
            ACT_POW:
            begin
                if (n == 0)
                    r.re = 32'(1) << FB;
                else
                begin
                    r.re = ar;
                    r.im = ai;
                    for (int k = 1; k < n; k++)
                    begin
                        cplx_mul(ar, ai, r.re, r.im, tr, ti, r.sat);
                        r.re = tr;
                        r.im = ti;
                    end
                end
            end
            ACT_CONJ:
            begin
                r.re = ar;
                r.im = clip(-128'(ai), r.sat);
            end
            ACT_NEG:
            begin
                r.re = clip(-128'(ar), r.sat);
                r.im = clip(-128'(ai), r.sat);
            end
            default:
            begin
                r.re = ar;
                r.im = ai;
            end
        endcase
        return r;
    endfunction

    task automatic idle_gap();
        if (idle_on && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge clk);
        end
    endtask

    task automatic send_word(input action_t op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi,
                             input logic [7:0] n);
        idle_gap();
        s_tdata <= {n, bi, br, ai, ar};
        s_tuser <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(alu_predict(op, ar, ai, br, bi, n));
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        cres_t e;
        if (m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
            else
            begin
                e = expected_q.pop_front();
                if (m_tdata[31:0] !== e.re) report_mismatch("res_re", m_tdata[31:0], e.re);
                if (m_tdata[63:32] !== e.im) report_mismatch("res_im", m_tdata[63:32], e.im);
                if (m_tuser[0] !== e.dz)
                    report_mismatch("div_zero", 32'(m_tuser[0]), 32'(e.dz));
                if (m_tuser[1] !== e.sat)
                    report_mismatch("saturated", 32'(m_tuser[1]), 32'(e.sat));
            end
        end
    end

    // receiver stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(7, 1)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(8 << FB)) - (4 << FB));
            3: return 32'($signed($urandom_range(1 << FB)) - (1 << (FB - 1)));
            4: return 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        logic [31:0] mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7FFF_FFFF;
        send_word(ACT_ADD, mx, mn, mx, mn, 8'd0);
        send_word(ACT_SUB, mn, mx, mx, mn, 8'd0);
        send_word(ACT_MUL, mn, mn, mn, mn, 8'd0);
        send_word(ACT_MUL, 32'h0001_8000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_4000, 8'd0);
        send_word(ACT_DIV, 32'h0003_0000, 32'h0001_0000, 32'd0, 32'd0, 8'd0);
        send_word(ACT_DIV, mx, mn, 32'd1, 32'd0, 8'd0);
        send_word(ACT_DIV, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 8'd0);
        send_word(ACT_DIV, 32'hFFFF_FFFF, 32'd1, mn, mx, 8'd0);
        send_word(ACT_POW, mx, mn, 32'd0, 32'd0, 8'd0);
        send_word(ACT_POW, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 8'd1);
        send_word(ACT_POW, 32'h0000_0000, 32'h0001_0000, 32'd0, 32'd0, 8'd4);
        send_word(ACT_POW, 32'h0002_0000, 32'h0001_0000, 32'd0, 32'd0, 8'd30);
        send_word(ACT_POW, 32'h0000_F000, 32'h0000_1000, 32'd0, 32'd0, 8'd255);
        send_word(ACT_CONJ, mn, mn, mx, mx, 8'hFF);
        send_word(ACT_CONJ, mx, mx, 32'd0, 32'd0, 8'd0);
        send_word(ACT_NEG, mn, mx, 32'd0, 32'd0, 8'd0);
        send_word(ACT_NEG, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd0);
        send_word(ACT_PLUS, mn, mx, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    endtask

    task automatic test_random(input int count);
        action_t op;
        logic [31:0] br, bi;
        logic [7:0] n;
        for (int k = 0; k < count; k++)
        begin
            op = action_t'($urandom_range(7));
            br = rnd_val();
            bi = rnd_val();
            if (op == ACT_DIV && $urandom_range(7) == 0)
            begin
                br = 32'd0;
                bi = 32'd0;
            end
            else if ($urandom_range(7) == 0)
                bi = 32'd0;
            n = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(6));
            send_word(op, rnd_val(), rnd_val(), br, bi, n);
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        test_random(400);
        idle_on = 1'b0;
        test_random(100);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
sv/cnalu_pkg.sv
sv/cnalu_dpath.sv
sv/cnalu_ctrl.sv
sv/complex_number_alu_unit.sv
sv/cnalu_checker.sv
tb/sv/tb_top.sv
